@@ design/one_shot_timer_multiplexer_assert.svh @@
// Assertion macros for the timer multiplexer
`ifndef ONE_SHOT_TIMER_MULTIPLEXER_ASSERT_SVH
`define ONE_SHOT_TIMER_MULTIPLEXER_ASSERT_SVH

// Plain clocked property, disabled in reset
`define OSTM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Antecedent this cycle, consequent in the next
`define OSTM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/ostm_pkg.sv @@
package ostm_pkg;

    localparam int TIMER_SLOTS_DEF = 16;
    localparam int TIME_W          = 32;
    localparam int TAG_W           = 8;

    localparam logic KIND_START  = 1'b0;
    localparam logic KIND_EXPIRE = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINAL
    } t_state;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] expiry;
    } t_slot;

    typedef struct packed {
        logic fire;
        logic place;
        logic take;
    } t_eval;

endpackage

@@ design/ostm_slot_ram.sv @@
module ostm_slot_ram
    import ostm_pkg::*;
#(
    parameter int DEPTH = TIMER_SLOTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  t_slot                    i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output t_slot                    o_rdata
);

    t_slot r_mem [DEPTH];
    t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/ostm_eval_unit.sv @@
module ostm_eval_unit
    import ostm_pkg::*;
(
    input  logic              i_kind,
    input  logic              i_active,
    input  logic              i_placed,
    input  logic              i_found,
    input  logic [TIME_W-1:0] i_slot_expiry,
    input  logic [TIME_W-1:0] i_new_expiry,
    input  logic [TIME_W-1:0] i_now,
    input  logic [TIME_W-1:0] i_best,
    output t_eval             o_eval,
    output logic [TIME_W-1:0] o_cand
);

    logic              place;
    logic              fire;
    logic              keep;
    logic [TIME_W-1:0] cand;

    always_comb begin
        place  = (i_kind == KIND_START) && !i_placed && !i_active;
        fire   = (i_kind == KIND_EXPIRE) && i_active && (i_slot_expiry <= i_now);
        cand   = place ? i_new_expiry : i_slot_expiry;
        keep   = (i_active && !fire) || place;
        o_eval = '{fire: fire, place: place, take: keep && (!i_found || (cand < i_best))};
        o_cand = cand;
    end

endmodule

@@ design/one_shot_timer_multiplexer.sv @@
// The final result is registered on the ports from S_FINAL, after the scan has evaluated the last slot.
// A new item is taken only in S_IDLE, after the one-slot-per-cycle scan
// through the slot memory and the shared evaluation unit; fired results come at most one per cycle.
// Results are strobed on o_valid for one cycle; the receiver cannot stall.
// Reset (synchronous, active low) clears all active marks and the sequencer.
`include "one_shot_timer_multiplexer_assert.svh"

module one_shot_timer_multiplexer
    import ostm_pkg::*;
#(
    parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_kind,
    input  logic [TIME_W-1:0] i_expiry_time,
    input  logic [TAG_W-1:0]  i_callback_tag,
    input  logic [TIME_W-1:0] i_now_time,
    output logic              o_valid,
    output logic              o_fired_valid,
    output logic [TAG_W-1:0]  o_fired_tag,
    output logic              o_arm_valid,
    output logic [TIME_W-1:0] o_arm_time,
    output logic              o_start_dropped,
    output logic              o_last
);

    localparam int IDX_W = $clog2(TIMER_SLOTS);
    localparam int CNT_W = $clog2(TIMER_SLOTS + 1);

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_ev_vld, n_ev_vld;
    logic [IDX_W-1:0]       r_ev_idx, n_ev_idx;
    logic                   r_kind, n_kind;
    logic [TIME_W-1:0]      r_exp, n_exp;
    logic [TAG_W-1:0]       r_tag, n_tag;
    logic [TIME_W-1:0]      r_now, n_now;
    logic                   r_placed, n_placed;
    logic                   r_found, n_found;
    logic [TIME_W-1:0]      r_best, n_best;
    logic [TIMER_SLOTS-1:0] r_active, n_active;

    logic                   r_valid, n_valid;
    logic                   r_fired_valid, n_fired_valid;
    logic [TAG_W-1:0]       r_fired_tag, n_fired_tag;
    logic                   r_arm_valid, n_arm_valid;
    logic [TIME_W-1:0]      r_arm_time, n_arm_time;
    logic                   r_start_dropped, n_start_dropped;
    logic                   r_last, n_last;

    logic                   rd_en;
    t_slot                  rd_slot;
    t_eval                  ev;
    logic [TIME_W-1:0]      ev_cand;

    assign rd_en = (r_state == S_SCAN) && (r_cnt < CNT_W'(TIMER_SLOTS));

    ostm_slot_ram #(
        .DEPTH (TIMER_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (r_ev_vld && ev.place),
        .i_waddr (r_ev_idx),
        .i_wdata ('{tag: r_tag, expiry: r_exp}),
        .i_re    (rd_en),
        .i_raddr (r_cnt[IDX_W-1:0]),
        .o_rdata (rd_slot)
    );

    ostm_eval_unit u_eval (
        .i_kind        (r_kind),
        .i_active      (r_active[r_ev_idx]),
        .i_placed      (r_placed),
        .i_found       (r_found),
        .i_slot_expiry (rd_slot.expiry),
        .i_new_expiry  (r_exp),
        .i_now         (r_now),
        .i_best        (r_best),
        .o_eval        (ev),
        .o_cand        (ev_cand)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ev_vld <= 1'b0;
            r_active <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ev_vld <= n_ev_vld;
            r_active <= n_active;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ev_idx        <= n_ev_idx;
        r_kind          <= n_kind;
        r_exp           <= n_exp;
        r_tag           <= n_tag;
        r_now           <= n_now;
        r_placed        <= n_placed;
        r_found         <= n_found;
        r_best          <= n_best;
        r_fired_valid   <= n_fired_valid;
        r_fired_tag     <= n_fired_tag;
        r_arm_valid     <= n_arm_valid;
        r_arm_time      <= n_arm_time;
        r_start_dropped <= n_start_dropped;
        r_last          <= n_last;
    end

    always_comb begin
        n_state         = r_state;
        n_cnt           = r_cnt;
        n_ev_vld        = rd_en;
        n_ev_idx        = r_cnt[IDX_W-1:0];
        n_kind          = r_kind;
        n_exp           = r_exp;
        n_tag           = r_tag;
        n_now           = r_now;
        n_placed        = r_placed;
        n_found         = r_found;
        n_best          = r_best;
        n_active        = r_active;
        n_valid         = 1'b0;
        n_fired_valid   = 1'b0;
        n_fired_tag     = '0;
        n_arm_valid     = 1'b0;
        n_arm_time      = '0;
        n_start_dropped = 1'b0;
        n_last          = 1'b0;

        if (rd_en) begin
            n_cnt = r_cnt + CNT_W'(1);
        end

        // evaluate the slot whose data has just come out of the memory
        if (r_ev_vld) begin
            if (ev.place) begin
                n_active[r_ev_idx] = 1'b1;
                n_placed           = 1'b1;
            end
            if (ev.fire) begin
                n_active[r_ev_idx] = 1'b0;
                n_valid            = 1'b1;
                n_fired_valid      = 1'b1;
                n_fired_tag        = rd_slot.tag;
            end
            if (ev.take) begin
                n_found = 1'b1;
                n_best  = ev_cand;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state  = S_SCAN;
                    n_cnt    = '0;
                    n_kind   = i_kind;
                    n_exp    = i_expiry_time;
                    n_tag    = i_callback_tag;
                    n_now    = i_now_time;
                    n_placed = 1'b0;
                    n_found  = 1'b0;
                    n_best   = '0;
                end
            end
            S_SCAN: begin
                if (r_ev_vld && (r_ev_idx == IDX_W'(TIMER_SLOTS - 1))) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                n_state         = S_IDLE;
                n_valid         = 1'b1;
                n_arm_valid     = r_found;
                n_arm_time      = r_found ? r_best : '0;
                n_start_dropped = (r_kind == KIND_START) && !r_placed;
                n_last          = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_fired_valid   = r_fired_valid;
    assign o_fired_tag     = r_fired_tag;
    assign o_arm_valid     = r_arm_valid;
    assign o_arm_time      = r_arm_time;
    assign o_start_dropped = r_start_dropped;
    assign o_last          = r_last;

    `OSTM_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
    `OSTM_ASSERT_NEXT(a_last_ends, o_valid && o_last, !o_valid, "result follows final result")
    `OSTM_ASSERT(a_fired_busy, o_valid && o_fired_valid |-> busy, "fired result outside scan")
    `OSTM_ASSERT(a_one_kind, o_valid |-> (o_fired_valid ^ o_last), "result neither fired nor final")

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import ostm_pkg::*;

    localparam int SLOTS        = TIMER_SLOTS_DEF;
    localparam int ITEM_CYCLES  = SLOTS + 3;
    localparam int RANDOM_ITEMS = 120;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic              fired_valid;
        logic [TAG_W-1:0]  fired_tag;
        logic              arm_valid;
        logic [TIME_W-1:0] arm_time;
        logic              start_dropped;
        logic              last;
    } timer_result_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_kind;
    logic [TIME_W-1:0] i_expiry_time;
    logic [TAG_W-1:0]  i_callback_tag;
    logic [TIME_W-1:0] i_now_time;
    logic              o_valid;
    logic              o_fired_valid;
    logic [TAG_W-1:0]  o_fired_tag;
    logic              o_arm_valid;
    logic [TIME_W-1:0] o_arm_time;
    logic              o_start_dropped;
    logic              o_last;

    logic              model_active [SLOTS];
    logic [TIME_W-1:0] model_expiry [SLOTS];
    logic [TAG_W-1:0]  model_tag    [SLOTS];

    timer_result_t     pending_timer_results[$];
    int                mismatch_count;
    int                cycle_count;
    bit                no_gap;

    one_shot_timer_multiplexer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_kind          (i_kind),
        .i_expiry_time   (i_expiry_time),
        .i_callback_tag  (i_callback_tag),
        .i_now_time      (i_now_time),
        .o_valid         (o_valid),
        .o_fired_valid   (o_fired_valid),
        .o_fired_tag     (o_fired_tag),
        .o_arm_valid     (o_arm_valid),
        .o_arm_time      (o_arm_time),
        .o_start_dropped (o_start_dropped),
        .o_last          (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    task automatic predict_timer_item(input logic kind, input logic [TIME_W-1:0] exp_t,
                                      input logic [TAG_W-1:0] tag_t,
                                      input logic [TIME_W-1:0] now_t);
        timer_result_t     r;
        logic              dropped;
        logic              found;
        logic [TIME_W-1:0] soonest;
        dropped = 1'b0;
        found   = 1'b0;
        soonest = '0;
        if (kind == KIND_START) begin
            dropped = 1'b1;
            for (int i = 0; i < SLOTS; i++) begin
                if (dropped && !model_active[i]) begin
                    model_active[i] = 1'b1;
                    model_expiry[i] = exp_t;
                    model_tag[i]    = tag_t;
                    dropped         = 1'b0;
                end
            end
        end else begin
            for (int i = 0; i < SLOTS; i++) begin
                if (model_active[i] && model_expiry[i] <= now_t) begin
                    model_active[i] = 1'b0;
                    r               = '0;
                    r.fired_valid   = 1'b1;
                    r.fired_tag     = model_tag[i];
                    pending_timer_results.push_back(r);
                end
            end
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (model_active[i] && (!found || model_expiry[i] < soonest)) begin
                soonest = model_expiry[i];
                found   = 1'b1;
            end
        end
        r               = '0;
        r.arm_valid     = found;
        r.arm_time      = found ? soonest : '0;
        r.start_dropped = dropped;
        r.last          = 1'b1;
        pending_timer_results.push_back(r);
    endtask

    // hold start and fields until accepted, then record what the item should produce
    task automatic issue_timer_item(input logic kind, input logic [TIME_W-1:0] exp_t,
                                    input logic [TAG_W-1:0] tag_t,
                                    input logic [TIME_W-1:0] now_t);
        int gaps;
        gaps = 0;
        while (!no_gap && $urandom_range(0, 99) < 27)
            gaps++;
        if (gaps > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gaps - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start          <= 1'b1;
        i_kind         <= kind;
        i_expiry_time  <= exp_t;
        i_callback_tag <= tag_t;
        i_now_time     <= now_t;
        do
            @(posedge i_clk);
        while (busy);
        predict_timer_item(kind, exp_t, tag_t, now_t);
    endtask

    always @(posedge i_clk) begin
        timer_result_t want;
        timer_result_t got;
        if (i_rst_n && o_valid) begin
            got = '{o_fired_valid, o_fired_tag, o_arm_valid, o_arm_time,
                    o_start_dropped, o_last};
            if (pending_timer_results.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected result: fired=%0b tag=%02h arm=%0b time=%08h drop=%0b last=%0b",
                             got.fired_valid, got.fired_tag, got.arm_valid, got.arm_time,
                             got.start_dropped, got.last);
                mismatch_count++;
            end else begin
                want = pending_timer_results.pop_front();
                if (got.fired_valid !== want.fired_valid || got.fired_tag !== want.fired_tag ||
                    got.arm_valid !== want.arm_valid || got.arm_time !== want.arm_time ||
                    got.start_dropped !== want.start_dropped || got.last !== want.last) begin
                    if (mismatch_count < 10) begin
                        $display("mismatch at %0t", $realtime);
                        $display("  expected fired=%0b tag=%02h arm=%0b time=%08h drop=%0b last=%0b",
                                 want.fired_valid, want.fired_tag, want.arm_valid,
                                 want.arm_time, want.start_dropped, want.last);
                        $display("  actual   fired=%0b tag=%02h arm=%0b time=%08h drop=%0b last=%0b",
                                 got.fired_valid, got.fired_tag, got.arm_valid, got.arm_time,
                                 got.start_dropped, got.last);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    task automatic test_empty_table();
        issue_timer_item(KIND_EXPIRE, 32'hFFFF_FFFF, 8'hFF, 32'h0000_0000);
    endtask

    task automatic test_time_extremes();
        issue_timer_item(KIND_START,  32'h0000_0000, 8'h00, 32'hFFFF_FFFF);
        issue_timer_item(KIND_START,  32'hFFFF_FFFF, 8'hFF, 32'h0000_0000);
        issue_timer_item(KIND_START,  32'h8000_0000, 8'h5A, 32'h1234_5678);
        issue_timer_item(KIND_START,  32'h8000_0000, 8'hA5, 32'h8765_4321);
        issue_timer_item(KIND_EXPIRE, 32'h0000_0000, 8'h00, 32'h0000_0000);
        issue_timer_item(KIND_EXPIRE, 32'hFFFF_FFFF, 8'hFF, 32'h8000_0000);
        issue_timer_item(KIND_EXPIRE, 32'h5555_5555, 8'h33, 32'hFFFF_FFFE);
        issue_timer_item(KIND_EXPIRE, 32'hAAAA_AAAA, 8'hCC, 32'hFFFF_FFFF);
    endtask

    task automatic test_table_full();
        for (int i = 0; i < SLOTS; i++)
            issue_timer_item(KIND_START, 32'h0001_0000 - 32'(i * 3), 8'(8'h10 + i),
                             $urandom);
        issue_timer_item(KIND_START, 32'h0000_0001, 8'hEE, $urandom);
        issue_timer_item(KIND_EXPIRE, $urandom, 8'($urandom), 32'hFFFF_FFFF);
    endtask

    task automatic test_random_traffic();
        logic [TIME_W-1:0] sim_now;
        logic [TIME_W-1:0] t;
        int                start_pct;
        int                pick;
        sim_now = $urandom_range(0, 32'h00FF_FFFF);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            no_gap    = (n >= 50 && n < 100);
            start_pct = (n % 60 < 35) ? 70 : 35;
            if ($urandom_range(0, 99) < start_pct) begin
                if ($urandom_range(0, 99) < 85)
                    t = sim_now + $urandom_range(1, 2000);
                else
                    t = $urandom;
                issue_timer_item(KIND_START, t, 8'($urandom), $urandom);
            end else begin
                sim_now = sim_now + $urandom_range(0, 800);
                pick    = $urandom_range(0, 99);
                if (pick < 5)
                    t = 32'hFFFF_FFFF;
                else if (pick < 12)
                    t = $urandom;
                else
                    t = sim_now;
                issue_timer_item(KIND_EXPIRE, $urandom, 8'($urandom), t);
            end
        end
        no_gap = 1'b0;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_timer_results.size() != 0)
            @(posedge i_clk);
        repeat (2 * ITEM_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_kind         = KIND_START;
        i_expiry_time  = '0;
        i_callback_tag = '0;
        i_now_time     = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        no_gap         = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            model_active[i] = 1'b0;
            model_expiry[i] = '0;
            model_tag[i]    = '0;
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_time_extremes();
        test_table_full();
        test_random_traffic();
        drain_results();

        if (mismatch_count == 0 && pending_timer_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/ostm_pkg.sv
design/ostm_slot_ram.sv
design/ostm_eval_unit.sv
design/one_shot_timer_multiplexer.sv
tb/tb_top.sv
